[rtl/glzw_pkg.sv]
// Package for the GIF LZW decoder: sequencer states, command and status codes.
// No dependencies; used by gif_lzw_decoder.
`timescale 1ns / 1ps
package glzw_pkg;

  localparam int BUF_BITS = 32;
  localparam int FILL_W   = 6;

  typedef enum logic [1:0] {
    FN_PUSH  = 2'd0,
    FN_PULL  = 2'd1,
    FN_START = 2'd2,
    FN_NONE  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_INDEX = 3'd1,
    ST_NEED  = 3'd2,
    ST_END   = 3'd3,
    ST_FULL  = 3'd4,
    ST_BAD   = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PULL,
    S_POP,
    S_CODE,
    S_WALK,
    S_WALK_RD
  } state_t;

endpackage

[rtl/glzw_table.sv]
// String table of the LZW decoder: prefix and suffix memories.
// One write port, one registered read port. Uses no package items.
`timescale 1ns / 1ps
module glzw_table #(
  parameter int ADDR_W = 12,
  parameter int SYM_W  = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [ADDR_W-1:0] wprefix,
  input  logic [SYM_W-1:0]  wsuffix,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [ADDR_W-1:0] rprefix,
  output logic [SYM_W-1:0]  rsuffix
);

  logic [ADDR_W-1:0] prefix_mem [2**ADDR_W];
  logic [SYM_W-1:0]  suffix_mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      prefix_mem[waddr] <= wprefix;
      suffix_mem[waddr] <= wsuffix;
    end
    if (re) begin
      rprefix <= prefix_mem[raddr];
      rsuffix <= suffix_mem[raddr];
    end
  end

endmodule

[rtl/glzw_stack.sv]
// Output stack of the LZW decoder: symbols of one string, last symbol first.
// One write port, one registered read port. Uses no package items.
`timescale 1ns / 1ps
module glzw_stack #(
  parameter int ADDR_W = 12,
  parameter int SYM_W  = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [SYM_W-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [SYM_W-1:0]  rdata
);

  logic [SYM_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

[rtl/gif_lzw_decoder.sv]
// GIF LZW decoder top level: bit buffer, code sequencer and string walk.
// Depends on glzw_pkg, glzw_table and glzw_stack.
//
// channel  dir  signals                    contents
// s_*      in   tvalid tready tdata tuser  tdata: data_byte[7:0]; tuser: func[1:0]
// m_*      out  tvalid tready tdata tuser  tdata: colour_index[7:0]; tuser: status[2:0]
// cfg_*    in   we wdata                   min_code_size[3:0]
//
// Push, start and idle commands answer from S_IDLE; a pull from a non-empty stack
// passes S_PULL and S_POP, and a pull that answers need-data or end with the stack
// empty answers from S_PULL. A pull that reads an end or invalid code answers from
// S_CODE; any other code goes on to S_WALK, with S_WALK_RD for each table symbol when
// the string walks the table memory, and each clear code read returns to S_PULL.
// One command is in work at a time; s_tready is low until its beat leaves m_*.
// Synchronous reset; no clearing pass, memories are read only where written.
`timescale 1ns / 1ps
module gif_lzw_decoder
  import glzw_pkg::*;
#(
  parameter int MAX_CODE_BITS = 12,
  parameter int INDEX_BITS    = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata,    // min_code_size
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,      // data_byte[7:0]
  input  logic [1:0] s_tuser,      // func[1:0]
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,      // colour_index[7:0]
  output logic [2:0] m_tuser       // status[2:0]
);

  localparam int MW    = MAX_CODE_BITS;
  localparam int CNT_W = MAX_CODE_BITS + 1;
  localparam int CW_W  = $clog2(MAX_CODE_BITS + 1);
  localparam logic [CNT_W-1:0] TABLE_SIZE = CNT_W'(1) << MW;
  localparam logic [CW_W-1:0]  CW_MAX     = CW_W'(MAX_CODE_BITS);
  localparam logic [3:0]       IDX_MAX    = 4'(INDEX_BITS);

  function automatic logic [3:0] eff_size(input logic [3:0] s);
    logic [3:0] r;
    r = s;
    if (s < 4'd2) r = 4'd2;
    if (s > IDX_MAX) r = IDX_MAX;
    return r;
  endfunction

  state_t state, state_next;

  logic [3:0]            min_code_size;
  logic [3:0]            root_size;
  logic [CW_W-1:0]       code_width;
  logic [CNT_W-1:0]      next_free_code;
  logic [CNT_W-1:0]      stack_count;
  logic [BUF_BITS-1:0]   bit_buffer;
  logic [FILL_W-1:0]     bit_fill;
  logic [MW-1:0]         previous_code;
  logic [INDEX_BITS-1:0] previous_first;
  logic                  previous_valid;
  logic                  stream_ended;
  logic [MW-1:0]         code;
  logic [MW-1:0]         walk_code;
  logic                  add_entry;

  logic [MW-1:0]         tbl_rprefix;
  logic [INDEX_BITS-1:0] tbl_rsuffix;
  logic [INDEX_BITS-1:0] stk_rdata;

  logic                  s_fire;
  func_t                 func;
  logic [MW-1:0]         clear_code, eoi_code;
  logic [BUF_BITS-1:0]   width_mask;
  logic [MW-1:0]         code_extract;
  logic [CNT_W-1:0]      count_inc;
  logic [CNT_W-1:0]      nfc_inc;
  logic [CNT_W-1:0]      width_limit;
  logic                  have_bits, buf_full, table_open;
  logic                  is_clear, is_eoi, is_bad, is_kwk;
  logic                  walk_more, rd_more;
  logic [3:0]            start_size;

  logic                  emit;
  status_t               emit_status;
  logic [INDEX_BITS-1:0] emit_index;
  logic                  tbl_we, tbl_re, stk_we, stk_re;
  logic [MW-1:0]         tbl_raddr, stk_waddr, stk_raddr;
  logic [INDEX_BITS-1:0] stk_wdata;

  assign s_tready     = (state == S_IDLE) && !m_tvalid;
  assign s_fire       = s_tvalid && s_tready;
  assign func         = func_t'(s_tuser);
  assign clear_code   = MW'(1) << root_size;
  assign eoi_code     = clear_code + MW'(1);
  assign width_mask   = ~({BUF_BITS{1'b1}} << code_width);
  assign code_extract = bit_buffer[MW-1:0] & width_mask[MW-1:0];
  assign count_inc    = stack_count + CNT_W'(1);
  assign nfc_inc      = next_free_code + CNT_W'(1);
  assign width_limit  = CNT_W'(1) << code_width;
  assign have_bits    = bit_fill >= FILL_W'(code_width);
  assign buf_full     = bit_fill > FILL_W'(BUF_BITS - 8);
  assign table_open   = next_free_code < TABLE_SIZE;
  assign is_clear     = code == clear_code;
  assign is_eoi       = code == eoi_code;
  assign is_kwk       = {1'b0, code} == next_free_code && table_open;
  assign is_bad       = previous_valid ? !({1'b0, code} < next_free_code || is_kwk)
                                       : (code > clear_code);
  assign walk_more    = walk_code > eoi_code && stack_count < TABLE_SIZE - CNT_W'(1);
  assign rd_more      = tbl_rprefix > eoi_code && count_inc < TABLE_SIZE - CNT_W'(1);
  assign start_size   = eff_size(min_code_size);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:    if (s_fire && func == FN_PULL) state_next = S_PULL;
      S_PULL: begin
        if (stack_count != '0) state_next = S_POP;
        else if (stream_ended || !have_bits) state_next = S_IDLE;
        else state_next = S_CODE;
      end
      S_POP:     state_next = S_IDLE;
      S_CODE: begin
        if (is_clear) state_next = S_PULL;
        else if (is_eoi || is_bad) state_next = S_IDLE;
        else state_next = S_WALK;
      end
      S_WALK:    state_next = walk_more ? S_WALK_RD : S_PULL;
      S_WALK_RD: state_next = rd_more ? S_WALK_RD : S_WALK;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    emit        = 1'b0;
    emit_status = ST_OK;
    emit_index  = '0;
    tbl_we      = 1'b0;
    tbl_re      = 1'b0;
    tbl_raddr   = walk_code;
    stk_we      = 1'b0;
    stk_waddr   = stack_count[MW-1:0];
    stk_wdata   = walk_code[INDEX_BITS-1:0];
    stk_re      = 1'b0;
    stk_raddr   = stack_count[MW-1:0] - MW'(1);
    case (state)
      S_IDLE: begin
        if (s_fire && func != FN_PULL) begin
          emit = 1'b1;
          if (func == FN_PUSH && buf_full) emit_status = ST_FULL;
        end
      end
      S_PULL: begin
        if (stack_count != '0) stk_re = 1'b1;
        else if (stream_ended) begin
          emit        = 1'b1;
          emit_status = ST_END;
        end else if (!have_bits) begin
          emit        = 1'b1;
          emit_status = ST_NEED;
        end
      end
      S_POP: begin
        emit        = 1'b1;
        emit_status = ST_INDEX;
        emit_index  = stk_rdata;
      end
      S_CODE: begin
        if (!is_clear && is_eoi) begin
          emit        = 1'b1;
          emit_status = ST_END;
        end else if (!is_clear && is_bad) begin
          emit        = 1'b1;
          emit_status = ST_BAD;
        end else if (!is_clear && previous_valid && !({1'b0, code} < next_free_code)) begin
          stk_we    = 1'b1;
          stk_waddr = '0;
          stk_wdata = previous_first;
        end
      end
      S_WALK: begin
        if (walk_more) tbl_re = 1'b1;
        else begin
          stk_we = stack_count < TABLE_SIZE;
          tbl_we = add_entry && table_open;
        end
      end
      S_WALK_RD: begin
        stk_we    = 1'b1;
        stk_wdata = tbl_rsuffix;
        tbl_re    = rd_more;
        tbl_raddr = tbl_rprefix;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      m_tvalid       <= 1'b0;
      m_tdata        <= '0;
      m_tuser        <= '0;
      min_code_size  <= 4'd8;
      root_size      <= eff_size(4'd8);
      code_width     <= CW_W'(eff_size(4'd8)) + CW_W'(1);
      next_free_code <= (CNT_W'(1) << eff_size(4'd8)) + CNT_W'(2);
      previous_valid <= 1'b0;
      previous_code  <= '0;
      previous_first <= '0;
      bit_buffer     <= '0;
      bit_fill       <= '0;
      stack_count    <= '0;
      stream_ended   <= 1'b0;
      code           <= '0;
      walk_code      <= '0;
      add_entry      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) min_code_size <= cfg_wdata;
      if (emit) begin
        m_tvalid <= 1'b1;
        m_tuser  <= emit_status;
        m_tdata  <= 8'(emit_index);
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_fire && func == FN_PUSH && !buf_full) begin
            bit_buffer <= bit_buffer | (BUF_BITS'(s_tdata) << bit_fill);
            bit_fill   <= bit_fill + FILL_W'(8);
          end
          if (s_fire && func == FN_START) begin
            root_size      <= start_size;
            code_width     <= CW_W'(start_size) + CW_W'(1);
            next_free_code <= (CNT_W'(1) << start_size) + CNT_W'(2);
            previous_valid <= 1'b0;
            previous_code  <= '0;
            previous_first <= '0;
            bit_buffer     <= '0;
            bit_fill       <= '0;
            stack_count    <= '0;
            stream_ended   <= 1'b0;
          end
        end
        S_PULL: begin
          if (stack_count != '0) stack_count <= stack_count - CNT_W'(1);
          else if (!stream_ended && have_bits) begin
            code       <= code_extract;
            bit_buffer <= bit_buffer >> code_width;
            bit_fill   <= bit_fill - FILL_W'(code_width);
          end
        end
        S_CODE: begin
          if (is_clear) begin
            code_width     <= CW_W'(root_size) + CW_W'(1);
            next_free_code <= (CNT_W'(1) << root_size) + CNT_W'(2);
            previous_valid <= 1'b0;
          end else if (is_eoi) begin
            stream_ended <= 1'b1;
          end else if (!is_bad) begin
            add_entry <= previous_valid;
            if (previous_valid && !({1'b0, code} < next_free_code)) begin
              walk_code   <= previous_code;
              stack_count <= CNT_W'(1);
            end else begin
              walk_code <= code;
            end
          end
        end
        S_WALK: begin
          if (!walk_more) begin
            if (stack_count < TABLE_SIZE) stack_count <= count_inc;
            previous_code  <= code;
            previous_first <= walk_code[INDEX_BITS-1:0];
            previous_valid <= 1'b1;
            if (add_entry && table_open) begin
              next_free_code <= nfc_inc;
              if (nfc_inc >= width_limit && code_width < CW_MAX)
                code_width <= code_width + CW_W'(1);
            end
          end
        end
        S_WALK_RD: begin
          stack_count <= count_inc;
          walk_code   <= tbl_rprefix;
        end
        default: ;
      endcase
    end
  end

  glzw_table #(
    .ADDR_W (MW),
    .SYM_W  (INDEX_BITS)
  ) u_table (
    .clk     (clk),
    .we      (tbl_we),
    .waddr   (next_free_code[MW-1:0]),
    .wprefix (previous_code),
    .wsuffix (walk_code[INDEX_BITS-1:0]),
    .re      (tbl_re),
    .raddr   (tbl_raddr),
    .rprefix (tbl_rprefix),
    .rsuffix (tbl_rsuffix)
  );

  glzw_stack #(
    .ADDR_W (MW),
    .SYM_W  (INDEX_BITS)
  ) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

endmodule
